/* rtl/core/odd_only_prime_sieve_count_macros.svh */
// assertion macros for the odd-only prime sieve counter
`ifndef ODD_ONLY_PRIME_SIEVE_COUNT_MACROS_SVH
`define ODD_ONLY_PRIME_SIEVE_COUNT_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define OPSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sieve counter assertion failed");

// antecedent implies consequent in the next cycle
`define OPSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sieve counter assertion failed");

`else

`define OPSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define OPSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/opsc_pkg.sv */
// shared widths for the odd-only prime sieve counter
package opsc_pkg;

  localparam int LIMIT_W   = 16;
  localparam int COUNT_W   = 13;
  localparam int PRIME_W   = 16;
  localparam int SQ_W      = 2 * PRIME_W;
  localparam int LIMIT_MAX = (2 ** LIMIT_W) - 1;

endpackage

/* rtl/core/opsc_if.sv */
// valid/ready channels for limit items and count items
interface opsc_in_if;
  import opsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] limit;

  modport source (output valid, output limit, input ready);
  modport sink   (input valid, input limit, output ready);
endinterface

interface opsc_out_if;
  import opsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] prime_count;
  logic               out_of_range;

  modport source (output valid, output prime_count, output out_of_range, input ready);
  modport sink   (input valid, input prime_count, input out_of_range, output ready);
endinterface

/* rtl/core/odd_only_prime_sieve_count.sv */
// Counts the primes up to a 16-bit limit with an odd-only sieve of Eratosthenes held in a
// one-bit-per-slot map memory (slot k stands for 2k+3). After reset the map is cleared in one
// pass over all MapDepth slots (32767 at the default MAX_N) before the first item is taken.
// An item with limit below two or above MAX_N skips the sieve and goes straight to the output.
// Otherwise the work runs on the map memory, which has one write port and one registered read
// port: each sieving prime is set up by a square and then a compare, each multiple is marked,
// the next prime is found by probing slots in turn, and a final count pass reads every slot in
// use and also clears the map for the next item. One item is in work at a time; a new item
// may be taken while the previous count still waits at the output.
module odd_only_prime_sieve_count #(
  parameter int MAX_N = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  opsc_in_if.sink           in_item,
  opsc_out_if.source        out_item
);
  import opsc_pkg::*;

  `include "odd_only_prime_sieve_count_macros.svh"

  localparam int CapN     = (MAX_N > LIMIT_MAX) ? LIMIT_MAX : MAX_N;
  localparam int MapDepth = (CapN - 1) / 2;
  localparam int AW       = $clog2(MapDepth);
  localparam int UW       = $clog2(MapDepth + 1);
  localparam int KW       = UW + 1;
  localparam logic [SQ_W-1:0] MaxNWide = SQ_W'(MAX_N);

  typedef enum logic [3:0] {
    CLR, IDLE, SQ, CHK, MARK, NEXT, SCAN_RD, SCAN_CHK, COUNT, DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [LIMIT_W-1:0] n_r, n_nxt;
  logic [UW-1:0]      used_r, used_nxt;
  logic [PRIME_W-1:0] p_r, p_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [UW-1:0]      scan_r, scan_nxt;
  logic [UW-1:0]      c_r, c_nxt;
  logic               pend_r, pend_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               oor_r, oor_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic               out_oor_r, out_oor_nxt;

  // map memory, one bit per odd number
  logic               map_mem [MapDepth];
  logic               rd_data_r;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               wr_data;

  // shared adder for mark stepping, slot stepping and sweep counters
  logic [KW-1:0]      alu_a, alu_b, alu_sum;

  logic [LIMIT_W-1:0] limit_m1;
  logic [SQ_W-1:0]    start_slot;

  assign alu_sum    = alu_a + alu_b;
  assign limit_m1   = in_item.limit - LIMIT_W'(1);
  assign start_slot = (sq_r - SQ_W'(3)) >> 1;

  assign in_item.ready         = (state_r == IDLE);
  assign out_item.valid        = out_valid_r;
  assign out_item.prime_count  = out_cnt_r;
  assign out_item.out_of_range = out_oor_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    used_nxt      = used_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    k_nxt         = k_r;
    scan_nxt      = scan_r;
    c_nxt         = c_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    out_oor_nxt   = out_oor_r;
    rd_addr       = scan_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = c_r[AW-1:0];
    wr_data       = 1'b0;
    alu_a         = KW'(c_r);
    alu_b         = KW'(1);

    if (out_valid_r && out_item.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      CLR: begin
        wr_en = 1'b1;
        c_nxt = alu_sum[UW-1:0];
        if (c_r == UW'(MapDepth - 1)) begin
          c_nxt     = '0;
          state_nxt = IDLE;
        end
      end
      IDLE: begin
        if (in_item.valid) begin
          n_nxt    = in_item.limit;
          used_nxt = UW'(limit_m1 >> 1);
          p_nxt    = PRIME_W'(3);
          scan_nxt = '0;
          c_nxt    = '0;
          pend_nxt = 1'b0;
          cnt_nxt  = '0;
          oor_nxt  = 1'b0;
          if ({{(SQ_W - LIMIT_W){1'b0}}, in_item.limit} > MaxNWide) begin
            oor_nxt   = 1'b1;
            state_nxt = DONE;
          end else if (in_item.limit < LIMIT_W'(2)) begin
            state_nxt = DONE;
          end else begin
            state_nxt = SQ;
          end
        end
      end
      SQ: begin
        sq_nxt    = {{(SQ_W - PRIME_W){1'b0}}, p_r} * {{(SQ_W - PRIME_W){1'b0}}, p_r};
        state_nxt = CHK;
      end
      CHK: begin
        if (sq_r > {{(SQ_W - LIMIT_W){1'b0}}, n_r}) begin
          state_nxt = COUNT;
        end else if (start_slot < SQ_W'(used_r)) begin
          k_nxt     = start_slot[KW-1:0];
          state_nxt = MARK;
        end else begin
          state_nxt = NEXT;
        end
      end
      MARK: begin
        wr_en   = 1'b1;
        wr_addr = k_r[AW-1:0];
        wr_data = 1'b1;
        alu_a   = k_r;
        alu_b   = KW'(p_r);
        k_nxt   = alu_sum;
        if (alu_sum >= KW'(used_r)) begin
          state_nxt = NEXT;
        end
      end
      NEXT: begin
        alu_a     = KW'(scan_r);
        scan_nxt  = alu_sum[UW-1:0];
        state_nxt = SCAN_RD;
      end
      SCAN_RD: begin
        // the probe stops at the last slot in use and never checks a slot past it
        if (scan_r >= used_r) begin
          state_nxt = COUNT;
        end else begin
          state_nxt = SCAN_CHK;
        end
      end
      SCAN_CHK: begin
        if (rd_data_r) begin
          state_nxt = NEXT;
        end else begin
          p_nxt     = PRIME_W'({scan_r, 1'b1}) + PRIME_W'(2);
          state_nxt = SQ;
        end
      end
      COUNT: begin
        // read each slot and clear it behind the read
        rd_addr = c_r[AW-1:0];
        if (pend_r && !rd_data_r) begin
          cnt_nxt = cnt_r + COUNT_W'(1);
        end
        if (c_r < used_r) begin
          wr_en    = 1'b1;
          pend_nxt = 1'b1;
          c_nxt    = alu_sum[UW-1:0];
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            // add one for the prime two
            cnt_nxt   = cnt_r + COUNT_W'(1);
            state_nxt = DONE;
          end
        end
      end
      DONE: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          out_oor_nxt   = oor_r;
          state_nxt     = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    used_r    <= used_nxt;
    p_r       <= p_nxt;
    sq_r      <= sq_nxt;
    k_r       <= k_nxt;
    scan_r    <= scan_nxt;
    cnt_r     <= cnt_nxt;
    oor_r     <= oor_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_oor_r <= out_oor_nxt;
    if (!rst_n) begin
      state_r     <= CLR;
      c_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      c_r         <= c_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= map_mem[rd_addr];
  end

  `OPSC_ASSERT_SAME(a_no_take_in_clear, clk, rst_n, state_r == CLR, !in_item.ready)
  `OPSC_ASSERT_SAME(a_mark_in_use, clk, rst_n, state_r == MARK, k_r < KW'(used_r))
  `OPSC_ASSERT_SAME(a_probe_after_read, clk, rst_n, state_r == SCAN_CHK, $past(state_r) == SCAN_RD)
  `OPSC_ASSERT_SAME(a_oor_zero_count, clk, rst_n, out_valid_r && out_oor_r, out_cnt_r == '0)
  `OPSC_ASSERT_NEXT(a_done_loads_out, clk, rst_n, state_r == DONE && (!out_valid_r || out_item.ready), out_valid_r)

endmodule

/* sim/odd_only_prime_sieve_count_tb.sv */
// testbench for the odd-only prime sieve counter: table of limits, random limits, checked counts
module odd_only_prime_sieve_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import opsc_pkg::*;

  localparam int SIEVE_MAX    = 65535;
  localparam int MAP_DEPTH    = 32768;
  localparam int RANDOM_ITEMS = 100;
  localparam int HOLD_CYCLES  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 3000000;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic [COUNT_W-1:0] count;
    logic               oor;
  } count_item_t;

  typedef struct {
    logic [LIMIT_W-1:0] limit;
    bit                 typed;
    logic [COUNT_W-1:0] count;
  } limit_row_t;

  // typed counts only where they are obvious; other rows go through the predictor
  limit_row_t directed_rows [23] = '{
    '{16'd0,     1'b1, 13'd0},
    '{16'd1,     1'b1, 13'd0},
    '{16'd2,     1'b1, 13'd1},
    '{16'd3,     1'b1, 13'd2},
    '{16'd4,     1'b0, 13'd0},
    '{16'd5,     1'b0, 13'd0},
    '{16'd7,     1'b0, 13'd0},
    '{16'd8,     1'b0, 13'd0},
    '{16'd9,     1'b0, 13'd0},
    '{16'd10,    1'b0, 13'd0},
    '{16'd24,    1'b0, 13'd0},
    '{16'd25,    1'b0, 13'd0},
    '{16'd26,    1'b0, 13'd0},
    '{16'd48,    1'b0, 13'd0},
    '{16'd49,    1'b0, 13'd0},
    '{16'd120,   1'b0, 13'd0},
    '{16'd121,   1'b0, 13'd0},
    '{16'd169,   1'b0, 13'd0},
    '{16'd1000,  1'b0, 13'd0},
    '{16'd4096,  1'b0, 13'd0},
    '{16'd32768, 1'b0, 13'd0},
    '{16'd65521, 1'b0, 13'd0},
    '{16'd65535, 1'b1, 13'd6542}
  };

  logic clk = 1'b0;
  logic rst_n;

  opsc_in_if  in_ch ();
  opsc_out_if out_ch ();

  odd_only_prime_sieve_count #(
    .MAX_N (SIEVE_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch.sink),
    .out_item (out_ch.source)
  );

  always #5 clk = ~clk;

  // predictor state
  bit                 odd_map [MAP_DEPTH];
  logic [PRIME_W-1:0] sieve_prime;
  logic [14:0]        probe_slot;
  logic [COUNT_W-1:0] tally;

  count_item_t expected_counts [$];

  int unsigned errors        = 0;
  int unsigned limits_sent   = 0;
  int unsigned counts_seen   = 0;
  int unsigned input_stalls  = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned cycle_count   = 0;
  int unsigned largest_limit = 0;
  bit          gaps_off      = 1'b0;

  function automatic count_item_t sieve_predict(input logic [LIMIT_W-1:0] n);
    count_item_t r;
    int unsigned used;
    int unsigned sq;
    int unsigned k;
    r.limit = n;
    r.count = '0;
    r.oor   = 1'b0;
    // not reachable with a 16-bit limit at the default bound, kept for other bounds
    if (n > SIEVE_MAX) begin
      r.oor = 1'b1;
      return r;
    end
    if (n < 2) return r;
    foreach (odd_map[j]) odd_map[j] = 1'b0;
    sieve_prime = 3;
    probe_slot  = '0;
    tally       = '0;
    used = (n - 1'b1) >> 1;
    if (used > MAP_DEPTH) used = MAP_DEPTH;
    sq = sieve_prime * sieve_prime;
    while (sq <= n) begin
      for (k = (sq - 3) / 2; k < used; k += sieve_prime) odd_map[k] = 1'b1;
      probe_slot++;
      // next prime search stays inside the slots in use
      while (probe_slot < used && odd_map[probe_slot]) probe_slot++;
      if (probe_slot >= used) break;
      sieve_prime = 2 * probe_slot + 3;
      sq = sieve_prime * sieve_prime;
    end
    for (k = 0; k < used; k++) if (!odd_map[k]) tally++;
    tally = tally + 1'b1;  // the prime 2
    r.count = tally;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit(input int idx);
    int unsigned r;
    r = $urandom_range(0, 99);
    // only a couple of large limits, the sieve is slowest at the top
    if (idx == 50 || idx == 85) return $urandom_range(4096, 65535);
    if (idx >= 20 && idx < 40) return $urandom_range(2, 200);
    if (r < 8) return $urandom_range(0, 12);
    if (r < 95) return $urandom_range(13, 1023);
    return $urandom_range(1024, 4095);
  endfunction

  task automatic report_mismatch(input string what, input logic [LIMIT_W-1:0] n,
                                 input int got, input int want);
    $display("mismatch at %0t: %s for limit %0d, got %0d want %0d", $realtime, what, n, got, want);
    errors++;
  endtask

  task automatic send_limit(input logic [LIMIT_W-1:0] n, input bit typed,
                            input logic [COUNT_W-1:0] typed_count);
    count_item_t e;
    int unsigned gap;
    gap = gaps_off ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.limit <= n;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (typed) begin
      e.limit = n;
      e.count = typed_count;
      e.oor   = 1'b0;
    end else begin
      e = sieve_predict(n);
    end
    expected_counts.push_back(e);
    limits_sent++;
    if (n > largest_limit) largest_limit = n;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : count_sink
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done < hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        gap = gaps_off ? 0 : pick_gap();
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : count_check
    count_item_t want;
    if (rst_n && in_ch.valid && !in_ch.ready) input_stalls++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      counts_seen++;
      if (expected_counts.size() == 0) begin
        report_mismatch("count item with nothing expected", '0, out_ch.prime_count, 0);
      end else begin
        want = expected_counts.pop_front();
        if (out_ch.prime_count !== want.count)
          report_mismatch("prime_count", want.limit, out_ch.prime_count, want.count);
        if (out_ch.out_of_range !== want.oor)
          report_mismatch("out_of_range", want.limit, out_ch.out_of_range, want.oor);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d counts outstanding", cycle_count,
               expected_counts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : limit_source
    int i;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.limit <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      send_limit(directed_rows[r].limit, directed_rows[r].typed, directed_rows[r].count);
    wait_drained();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // no idling on either side while the result side holds off, so the block backs up
      if (i == 20) begin
        gaps_off = 1'b1;
        hold_requests++;
      end
      if (i == 40) gaps_off = 1'b0;
      if (i == 60) wait_drained();
      if (i == 70) gaps_off = 1'b1;
      if (i == 80) gaps_off = 1'b0;
      send_limit(pick_limit(i), 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d limits (%0d from the table), largest %0d, %0d counts checked",
             limits_sent, $size(directed_rows), largest_limit, counts_seen);
    $display("long output hold-off done %0d time(s), input stalled for %0d cycles",
             holds_done, input_stalls);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
